@@ rtl/scpf_pkg.sv @@
// ----------------------------------------------------------------------------
// scpf_pkg: shared types and codes of the peephole fuser
// Token and result layouts, word codes, fused op codes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package scpf_pkg;

   localparam int IDENT_WIDTH   = 16;
   localparam int LITERAL_WIDTH = 64;
   localparam int WIN_DEPTH     = 4;
   localparam int CNT_W         = $clog2(WIN_DEPTH + 1);
   localparam int SHAMT_W       = $clog2(LITERAL_WIDTH);

   // token kinds
   localparam logic [1:0] K_LIT = 2'd0;
   localparam logic [1:0] K_VAR = 2'd1;

   // word codes
   localparam logic [4:0] C_ADD    = 5'd1;
   localparam logic [4:0] C_SUB    = 5'd2;
   localparam logic [4:0] C_MUL    = 5'd3;
   localparam logic [4:0] C_DIV    = 5'd4;
   localparam logic [4:0] C_LT     = 5'd5;
   localparam logic [4:0] C_GT     = 5'd6;
   localparam logic [4:0] C_EQ     = 5'd7;
   localparam logic [4:0] C_RFROM  = 5'd8;
   localparam logic [4:0] C_TOR    = 5'd9;
   localparam logic [4:0] C_RAT    = 5'd10;
   localparam logic [4:0] C_CSTORE = 5'd11;
   localparam logic [4:0] C_STORE  = 5'd12;
   localparam logic [4:0] C_FETCH  = 5'd13;
   localparam logic [4:0] C_DUP    = 5'd14;
   localparam logic [4:0] C_SWAP   = 5'd15;
   localparam logic [4:0] C_DROP   = 5'd16;
   localparam logic [4:0] C_ROT    = 5'd17;
   localparam logic [4:0] C_OVER   = 5'd18;

   // fused ops
   localparam logic [4:0] OP_ADD_IMM   = 5'd0;
   localparam logic [4:0] OP_SUB_IMM   = 5'd1;
   localparam logic [4:0] OP_SHL_IMM   = 5'd2;
   localparam logic [4:0] OP_MUL_IMM   = 5'd3;
   localparam logic [4:0] OP_SHR_IMM   = 5'd4;
   localparam logic [4:0] OP_DIV_IMM   = 5'd5;
   localparam logic [4:0] OP_CMP_LT    = 5'd6;
   localparam logic [4:0] OP_CMP_GT    = 5'd7;
   localparam logic [4:0] OP_CMP_EQ    = 5'd8;
   localparam logic [4:0] OP_INC_R     = 5'd9;
   localparam logic [4:0] OP_DEC_R     = 5'd10;
   localparam logic [4:0] OP_R_CSTORE  = 5'd11;
   localparam logic [4:0] OP_R_STORE   = 5'd12;
   localparam logic [4:0] OP_VAR_FETCH = 5'd13;
   localparam logic [4:0] OP_VAR_STORE = 5'd14;
   localparam logic [4:0] OP_LEA_TOS   = 5'd15;
   localparam logic [4:0] OP_MOV_TOS_1 = 5'd16;
   localparam logic [4:0] OP_TUCK      = 5'd17;
   localparam logic [4:0] OP_DUP       = 5'd18;

   // result kinds
   localparam logic [1:0] OK_PASS  = 2'd0;
   localparam logic [1:0] OK_FUSED = 2'd1;
   localparam logic [1:0] OK_END   = 2'd2;
   localparam logic [1:0] OK_DIV0  = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic [4:0]               code;
      logic [IDENT_WIDTH-1:0]   ident;
      logic [LITERAL_WIDTH-1:0] literal;
   } tok_type;

   typedef struct packed {
      logic [1:0]               out_kind;
      logic [1:0]               token_kind;
      logic [4:0]               word_code;
      logic [4:0]               fused_op;
      logic [IDENT_WIDTH-1:0]   ident;
      logic [LITERAL_WIDTH-1:0] value;
      logic                     last;
   } res_type;

   function automatic logic is_word(tok_type t, logic [4:0] code);
      return (t.kind != K_LIT) && (t.kind != K_VAR) && (t.code == code);
   endfunction

endpackage

`default_nettype wire

@@ rtl/scpf_decide.sv @@
// ----------------------------------------------------------------------------
// scpf_decide: greedy pattern match at the oldest window token
// Produces one result and the number of tokens it covers.
// ----------------------------------------------------------------------------
`default_nettype none

module scpf_decide import scpf_pkg::*; (
   input  tok_type [WIN_DEPTH-1:0] win,
   input  logic [CNT_W-1:0]        count,
   output res_type                 res,
   output logic [CNT_W-1:0]        consumed
);

   function automatic res_type mk_fused(logic [4:0] op, logic [IDENT_WIDTH-1:0] id,
                                        logic [LITERAL_WIDTH-1:0] val);
      res_type r;
      r          = '0;
      r.out_kind = OK_FUSED;
      r.fused_op = op;
      r.ident    = id;
      r.value    = val;
      return r;
   endfunction

   tok_type                  t0, t1, t2, t3;
   logic [LITERAL_WIDTH-1:0] lit;
   logic [LITERAL_WIDTH-1:0] lit_m1;
   logic                     lit_pow2;
   logic                     lit_zero;
   logic                     lit_one;
   logic [SHAMT_W-1:0]       shamt;
   logic [LITERAL_WIDTH-1:0] shamt_ext;
   logic                     has4;
   logic                     has2;

   assign t0 = win[0];
   assign t1 = win[1];
   assign t2 = win[2];
   assign t3 = win[3];
   assign lit      = t0.literal;
   assign lit_m1   = lit - LITERAL_WIDTH'(1);
   assign lit_zero = (lit == '0);
   assign lit_one  = (lit == LITERAL_WIDTH'(1));
   assign lit_pow2 = !lit_zero && !lit[LITERAL_WIDTH-1] && ((lit & lit_m1) == '0);
   assign has4     = (count == CNT_W'(WIN_DEPTH));
   assign has2     = (count >= CNT_W'(2));
   assign shamt_ext = LITERAL_WIDTH'(shamt);

   // bit index of a single set bit
   always_comb begin
      shamt = '0;
      for (int i = 0; i < LITERAL_WIDTH; i++) begin
         if (lit[i]) begin
            shamt = shamt | SHAMT_W'(i);
         end
      end
   end

   always_comb begin
      res            = '0;
      res.out_kind   = OK_PASS;
      res.token_kind = t0.kind;
      res.word_code  = t0.code;
      res.ident      = t0.ident;
      res.value      = (t0.kind == K_LIT) ? lit : '0;
      consumed       = CNT_W'(1);
      if (has4 && is_word(t0, C_RFROM) && (t1.kind == K_LIT) && is_word(t3, C_TOR) &&
          (is_word(t2, C_ADD) || is_word(t2, C_SUB))) begin
         res      = mk_fused(is_word(t2, C_ADD) ? OP_INC_R : OP_DEC_R, '0, t1.literal);
         consumed = CNT_W'(4);
      end else if (has2) begin
         consumed = CNT_W'(2);
         if (is_word(t0, C_RAT) && is_word(t1, C_CSTORE)) begin
            res = mk_fused(OP_R_CSTORE, '0, '0);
         end else if (is_word(t0, C_RAT) && is_word(t1, C_STORE)) begin
            res = mk_fused(OP_R_STORE, '0, '0);
         end else if ((t0.kind == K_VAR) && is_word(t1, C_FETCH)) begin
            res = mk_fused(OP_VAR_FETCH, t0.ident, '0);
         end else if ((t0.kind == K_VAR) && is_word(t1, C_STORE)) begin
            res = mk_fused(OP_VAR_STORE, t0.ident, '0);
         end else if (is_word(t0, C_DUP) && is_word(t1, C_ADD)) begin
            res = mk_fused(OP_LEA_TOS, '0, '0);
         end else if (is_word(t0, C_SWAP) && is_word(t1, C_DROP)) begin
            res = mk_fused(OP_MOV_TOS_1, '0, '0);
         end else if (is_word(t0, C_DUP) && is_word(t1, C_ROT)) begin
            res = mk_fused(OP_TUCK, '0, '0);
         end else if (is_word(t0, C_OVER) && is_word(t1, C_DROP)) begin
            res = mk_fused(OP_DUP, '0, '0);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_ADD)) begin
            res = mk_fused(OP_ADD_IMM, '0, lit);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_SUB)) begin
            res = mk_fused(OP_SUB_IMM, '0, lit);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_MUL) && !lit_one) begin
            res = lit_pow2 ? mk_fused(OP_SHL_IMM, '0, shamt_ext)
                           : mk_fused(OP_MUL_IMM, '0, lit);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_DIV) && lit_zero) begin
            res          = '0;
            res.out_kind = OK_DIV0;
         end else if ((t0.kind == K_LIT) && is_word(t1, C_DIV) && !lit_one) begin
            res = lit_pow2 ? mk_fused(OP_SHR_IMM, '0, shamt_ext)
                           : mk_fused(OP_DIV_IMM, '0, lit);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_LT)) begin
            res = mk_fused(OP_CMP_LT, '0, lit);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_GT)) begin
            res = mk_fused(OP_CMP_GT, '0, lit);
         end else if ((t0.kind == K_LIT) && is_word(t1, C_EQ)) begin
            res = mk_fused(OP_CMP_EQ, '0, lit);
         end else begin
            consumed = CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/scpf_window.sv @@
// ----------------------------------------------------------------------------
// scpf_window: lookahead window and flush control
// Holds up to 4 tokens, one decision per cycle unless stalled, drains on last.
// ----------------------------------------------------------------------------
`default_nettype none

module scpf_window import scpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tok_type                  req_tok,
   input  logic                     req_last,
   input  logic                     out_ready,
   output logic                     out_load,
   output res_type                  out_res
);

   tok_type [WIN_DEPTH-1:0] win_ff, win_in, shifted;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    drain_ff, drain_in;
   res_type                 dec_res;
   logic [CNT_W-1:0]        dec_cons;
   logic [CNT_W-1:0]        cons;
   logic [CNT_W-1:0]        remain;
   logic [CNT_W-1:0]        src;
   logic                    full;
   logic                    do_decide;
   logic                    do_end;
   logic                    accept;
   res_type                 end_res;

   scpf_decide u_decide (
      .win      (win_ff),
      .count    (count_ff),
      .res      (dec_res),
      .consumed (dec_cons)
   );

   assign full      = (count_ff == CNT_W'(WIN_DEPTH));
   assign do_decide = out_ready && (full || (drain_ff && (count_ff != '0)));
   assign do_end    = out_ready && drain_ff && (count_ff == '0);
   assign req_stall = drain_ff || (full && !do_decide);
   assign accept    = req_valid && !req_stall;
   assign cons      = do_decide ? dec_cons : '0;
   assign remain    = count_ff - cons;

   always_comb begin
      end_res          = '0;
      end_res.out_kind = OK_END;
      end_res.last     = 1'b1;
   end

   assign out_load = do_decide || do_end;
   assign out_res  = do_end ? end_res : dec_res;

   always_comb begin
      shifted = win_ff;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         src = CNT_W'(i) + cons;
         if (src < CNT_W'(WIN_DEPTH)) begin
            shifted[i] = win_ff[src[CNT_W-2:0]];
         end
      end
      win_in = shifted;
      if (accept) begin
         win_in[remain[CNT_W-2:0]] = req_tok;
      end
      count_in = remain + CNT_W'(accept);
      drain_in = drain_ff;
      if (accept && req_last) begin
         drain_in = 1'b1;
      end else if (do_end) begin
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drain_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

@@ rtl/scpf_outreg.sv @@
// ----------------------------------------------------------------------------
// scpf_outreg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scpf_outreg import scpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  res_type res,
   output logic    ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output res_type rsp_res
);

   logic    valid_ff, valid_in;
   res_type res_ff;

   assign ready     = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule

`default_nettype wire

@@ rtl/stack_code_peephole_fuser.sv @@
// ----------------------------------------------------------------------------
// stack_code_peephole_fuser: peephole macro-op fuser for stack-machine tokens
// Fuses common token patterns over a four-token lookahead window.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | token kind, code, ident, literal, last
//  rsp_    | out       | rsp_valid/rsp_stall  | result kind, token, op, ident, value, last
//
//  One token per cycle steady state while results are taken; each decision is
//  made combinationally from the window register and loaded into the result register.
//  A last token drains the window at one result per cycle while results are taken
//  (up to four) and then the end marker; req_stall is high for that whole drain.
//  With four tokens held and the result register stalled, req_stall is high.
//  Reset (synchronous) empties the window and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_code_peephole_fuser import scpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_token_kind,
   input  logic [4:0]               req_word_code,
   input  logic [IDENT_WIDTH-1:0]   req_word_ident,
   input  logic [LITERAL_WIDTH-1:0] req_literal_value,
   input  logic                     req_last_token,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_out_kind,
   output logic [1:0]               rsp_out_token_kind,
   output logic [4:0]               rsp_out_word_code,
   output logic [4:0]               rsp_fused_op,
   output logic [IDENT_WIDTH-1:0]   rsp_out_ident,
   output logic [LITERAL_WIDTH-1:0] rsp_out_value,
   output logic                     rsp_out_last
);

   tok_type req_tok;
   logic    out_ready;
   logic    out_load;
   res_type out_res;
   res_type rsp_res;

   assign req_tok.kind    = req_token_kind;
   assign req_tok.code    = req_word_code;
   assign req_tok.ident   = req_word_ident;
   assign req_tok.literal = req_literal_value;

   scpf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_tok   (req_tok),
      .req_last  (req_last_token),
      .out_ready (out_ready),
      .out_load  (out_load),
      .out_res   (out_res)
   );

   scpf_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .res       (out_res),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_out_kind       = rsp_res.out_kind;
   assign rsp_out_token_kind = rsp_res.token_kind;
   assign rsp_out_word_code  = rsp_res.word_code;
   assign rsp_fused_op       = rsp_res.fused_op;
   assign rsp_out_ident      = rsp_res.ident;
   assign rsp_out_value      = rsp_res.value;
   assign rsp_out_last       = rsp_res.last;

endmodule

`default_nettype wire

@@ rtl/scpf_checker.sv @@
// ----------------------------------------------------------------------------
// scpf_checker: port-level checks for the peephole fuser
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scpf_checker import scpf_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     req_last_token,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [1:0]               rsp_out_kind,
   input logic [4:0]               rsp_fused_op,
   input logic [IDENT_WIDTH-1:0]   rsp_out_ident,
   input logic [LITERAL_WIDTH-1:0] rsp_out_value,
   input logic                     rsp_out_last
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result transaction dropped");

   a_last_stalls_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_token |=> req_stall)
      else $error("input taken while flushing");

   a_pass_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == OK_PASS) |-> (rsp_fused_op == '0) && !rsp_out_last)
      else $error("passthrough result carries op or last");

   a_div0_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == OK_DIV0) |->
         (rsp_out_value == '0) && (rsp_out_ident == '0) && !rsp_out_last)
      else $error("division error result not cleared");

endmodule

bind stack_code_peephole_fuser scpf_checker u_scpf_checker (.*);

`default_nettype wire

@@ tb/peephole_result_checker.sv @@
// ----------------------------------------------------------------------------
// peephole_result_checker: transaction checker for the peephole fuser
// Watches the token and result channels. Every accepted token goes into a
// private four-token window that makes the same greedy fusion decisions as
// the block. The expected results are queued and compared field by field
// against each accepted result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module peephole_result_checker import scpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_token_kind,
   input  logic [4:0]               req_word_code,
   input  logic [IDENT_WIDTH-1:0]   req_word_ident,
   input  logic [LITERAL_WIDTH-1:0] req_literal_value,
   input  logic                     req_last_token,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [1:0]               rsp_out_kind,
   input  logic [1:0]               rsp_out_token_kind,
   input  logic [4:0]               rsp_out_word_code,
   input  logic [4:0]               rsp_fused_op,
   input  logic [IDENT_WIDTH-1:0]   rsp_out_ident,
   input  logic [LITERAL_WIDTH-1:0] rsp_out_value,
   input  logic                     rsp_out_last,
   output int                       fail_count,
   output int                       expect_depth,
   output int                       results_seen,
   output int                       fused_seen,
   output int                       div0_seen
);

   tok_type     window [0:WIN_DEPTH-1];
   int unsigned held;
   res_type     expected_results [$];

   // kinds 2 and 3 are plain words
   function automatic logic is_plain_word(tok_type t, logic [4:0] code);
      return t.kind[1] && (t.code == code);
   endfunction

   function automatic logic power_of_two(logic [LITERAL_WIDTH-1:0] v);
      return (v != '0) && !v[LITERAL_WIDTH-1] && ((v & (v - 1'b1)) == '0);
   endfunction

   function automatic logic [LITERAL_WIDTH-1:0] trailing_zeros(logic [LITERAL_WIDTH-1:0] v);
      int unsigned n;
      n = 0;
      while (n < LITERAL_WIDTH - 1 && !v[n]) n++;
      return LITERAL_WIDTH'(n);
   endfunction

   // one greedy decision at the oldest held token; returns tokens consumed
   function automatic int unsigned fuse_window_head(int unsigned n, output res_type r);
      tok_type                  t0;
      tok_type                  t1;
      logic [LITERAL_WIDTH-1:0] lit;
      logic [LITERAL_WIDTH-1:0] val;
      logic [4:0]               op;
      logic                     hit;
      t0  = window[0];
      t1  = window[1];
      lit = t0.literal;
      r   = '0;
      r.out_kind = OK_FUSED;
      if (n >= 4 && is_plain_word(t0, C_RFROM) && t1.kind == K_LIT &&
          is_plain_word(window[3], C_TOR) &&
          (is_plain_word(window[2], C_ADD) || is_plain_word(window[2], C_SUB))) begin
         r.fused_op = is_plain_word(window[2], C_ADD) ? OP_INC_R : OP_DEC_R;
         r.value    = t1.literal;
         return 4;
      end
      if (n >= 2) begin
         hit = 1'b1;
         val = '0;
         op  = '0;
         if (is_plain_word(t0, C_RAT) && is_plain_word(t1, C_CSTORE)) op = OP_R_CSTORE;
         else if (is_plain_word(t0, C_RAT) && is_plain_word(t1, C_STORE)) op = OP_R_STORE;
         else if (t0.kind == K_VAR && is_plain_word(t1, C_FETCH)) op = OP_VAR_FETCH;
         else if (t0.kind == K_VAR && is_plain_word(t1, C_STORE)) op = OP_VAR_STORE;
         else if (is_plain_word(t0, C_DUP) && is_plain_word(t1, C_ADD)) op = OP_LEA_TOS;
         else if (is_plain_word(t0, C_SWAP) && is_plain_word(t1, C_DROP)) op = OP_MOV_TOS_1;
         else if (is_plain_word(t0, C_DUP) && is_plain_word(t1, C_ROT)) op = OP_TUCK;
         else if (is_plain_word(t0, C_OVER) && is_plain_word(t1, C_DROP)) op = OP_DUP;
         else if (t0.kind != K_LIT) hit = 1'b0;
         else if (is_plain_word(t1, C_ADD)) begin
            op  = OP_ADD_IMM;
            val = lit;
         end else if (is_plain_word(t1, C_SUB)) begin
            op  = OP_SUB_IMM;
            val = lit;
         end else if (is_plain_word(t1, C_MUL) && lit != 1) begin
            op  = power_of_two(lit) ? OP_SHL_IMM : OP_MUL_IMM;
            val = power_of_two(lit) ? trailing_zeros(lit) : lit;
         end else if (is_plain_word(t1, C_DIV) && lit == 0) begin
            r.out_kind = OK_DIV0;
         end else if (is_plain_word(t1, C_DIV) && lit != 1) begin
            op  = power_of_two(lit) ? OP_SHR_IMM : OP_DIV_IMM;
            val = power_of_two(lit) ? trailing_zeros(lit) : lit;
         end else if (is_plain_word(t1, C_LT)) begin
            op  = OP_CMP_LT;
            val = lit;
         end else if (is_plain_word(t1, C_GT)) begin
            op  = OP_CMP_GT;
            val = lit;
         end else if (is_plain_word(t1, C_EQ)) begin
            op  = OP_CMP_EQ;
            val = lit;
         end else hit = 1'b0;
         if (hit) begin
            r.fused_op = op;
            r.value    = val;
            if (r.out_kind == OK_FUSED && (op == OP_VAR_FETCH || op == OP_VAR_STORE))
               r.ident = t0.ident;
            return 2;
         end
      end
      r            = '0;
      r.out_kind   = OK_PASS;
      r.token_kind = t0.kind;
      r.word_code  = t0.code;
      r.ident      = t0.ident;
      if (t0.kind == K_LIT) r.value = lit;
      return 1;
   endfunction

   function automatic void retire_oldest();
      res_type     r;
      int unsigned used;
      used = fuse_window_head(held, r);
      expected_results = {expected_results, r};
      for (int i = 0; i + used < WIN_DEPTH; i++) window[i] = window[i + used];
      held -= used;
   endfunction

   function automatic void take_token(tok_type t, logic last);
      res_type mark;
      window[held] = t;
      held++;
      if (last) begin
         while (held > 0) retire_oldest();
         mark          = '0;
         mark.out_kind = OK_END;
         mark.last     = 1'b1;
         expected_results = {expected_results, mark};
      end else if (held == WIN_DEPTH) begin
         retire_oldest();
      end
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      tok_type t;
      res_type e;
      if (reset) begin
         held = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected, expected none, got kind %0h value %0h",
                        $time, rsp_out_kind, rsp_out_value);
            end else begin
               e = expected_results.pop_front();
               if (e.out_kind == OK_FUSED) fused_seen++;
               if (e.out_kind == OK_DIV0) div0_seen++;
               compare_field("out_kind", 64'(e.out_kind), 64'(rsp_out_kind));
               compare_field("out_token_kind", 64'(e.token_kind), 64'(rsp_out_token_kind));
               compare_field("out_word_code", 64'(e.word_code), 64'(rsp_out_word_code));
               compare_field("fused_op", 64'(e.fused_op), 64'(rsp_fused_op));
               compare_field("out_ident", 64'(e.ident), 64'(rsp_out_ident));
               compare_field("out_value", 64'(e.value), 64'(rsp_out_value));
               compare_field("out_last", 64'(e.last), 64'(rsp_out_last));
            end
         end
         if (req_valid && !req_stall) begin
            t.kind    = req_token_kind;
            t.code    = req_word_code;
            t.ident   = req_word_ident;
            t.literal = req_literal_value;
            take_token(t, req_last_token);
         end
      end
      expect_depth = expected_results.size();
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top level testbench of the stack-code peephole fuser
// Sends directed token lists covering several fusions and corner cases, then
// random lists built mostly from fusable patterns with noise mixed in. The
// sender works in bursts, the receiver stalls in its own pattern including a
// long hold that fills the window. The checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import scpf_pkg::*; ();

   localparam int         RANDOM_TOKENS = 125;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         DRAIN_CYCLES  = 20;
   localparam logic [1:0] K_WORD        = 2'd2;
   localparam logic [1:0] K_WORD_ALT    = 2'd3;
   localparam logic [4:0] C_CODE_MAX    = 5'd31;
   localparam logic [4:0] PAIR_HEAD [6] = '{C_RAT, C_RAT, C_DUP, C_SWAP, C_DUP, C_OVER};
   localparam logic [4:0] PAIR_TAIL [6] = '{C_CSTORE, C_STORE, C_ADD, C_DROP, C_ROT, C_DROP};
   localparam logic [4:0] LIT_OPS   [7] = '{C_ADD, C_SUB, C_MUL, C_DIV, C_LT, C_GT, C_EQ};

   typedef struct {
      tok_type tok;
      logic    last;
   } stim_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_token_kind;
   logic [4:0]               req_word_code;
   logic [IDENT_WIDTH-1:0]   req_word_ident;
   logic [LITERAL_WIDTH-1:0] req_literal_value;
   logic                     req_last_token;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_out_kind;
   logic [1:0]               rsp_out_token_kind;
   logic [4:0]               rsp_out_word_code;
   logic [4:0]               rsp_fused_op;
   logic [IDENT_WIDTH-1:0]   rsp_out_ident;
   logic [LITERAL_WIDTH-1:0] rsp_out_value;
   logic                     rsp_out_last;
   int                       fail_count;
   int                       expect_depth;
   int                       results_seen;
   int                       fused_seen;
   int                       div0_seen;

   stim_type token_list [$];
   int       list_count;

   stack_code_peephole_fuser DUT (.*);

   peephole_result_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [LITERAL_WIDTH-1:0] pick_literal();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 64'd1;
         2:       return '1;
         3:       return 64'h8000_0000_0000_0000;
         4:       return 64'h7fff_ffff_ffff_ffff;
         5, 6:    return 64'd1 << $urandom_range(0, 62);
         7:       return -(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic tok_type word(logic [4:0] code);
      tok_type t;
      t.kind    = $urandom_range(0, 1) ? K_WORD : K_WORD_ALT;
      t.code    = code;
      t.ident   = IDENT_WIDTH'($urandom_range(0, 16'hffff));
      t.literal = {$urandom, $urandom};
      return t;
   endfunction

   function automatic tok_type literal_tok(logic [LITERAL_WIDTH-1:0] v);
      tok_type t;
      t.kind    = K_LIT;
      t.code    = 5'($urandom_range(0, 31));
      t.ident   = IDENT_WIDTH'($urandom_range(0, 16'hffff));
      t.literal = v;
      return t;
   endfunction

   function automatic tok_type variable_tok();
      tok_type t;
      t      = word(5'($urandom_range(0, 31)));
      t.kind = K_VAR;
      return t;
   endfunction

   function automatic tok_type noise_tok();
      tok_type t;
      t      = word(5'($urandom_range(0, 31)));
      t.kind = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) t.literal = pick_literal();
      return t;
   endfunction

   function automatic void add_token(tok_type t);
      stim_type s;
      s.tok  = t;
      s.last = 1'b0;
      token_list = {token_list, s};
   endfunction

   function automatic void end_list();
      token_list[token_list.size() - 1].last = 1'b1;
      list_count++;
   endfunction

   function automatic void build_directed();
      tok_type t;
      add_token(word(C_RFROM));
      add_token(literal_tok(64'd5));
      add_token(word(C_ADD));
      add_token(word(C_TOR));
      add_token(word(C_RFROM));
      add_token(literal_tok(64'h7fff_ffff_ffff_ffff));
      add_token(word(C_SUB));
      add_token(word(C_TOR));
      add_token(literal_tok(64'h4000_0000_0000_0000));
      add_token(word(C_MUL));
      add_token(literal_tok('0));
      add_token(word(C_DIV));
      add_token(literal_tok(64'd1));
      add_token(word(C_MUL));
      add_token(literal_tok(64'd1));
      add_token(word(C_DIV));
      t = word(C_DUP);
      t.kind = K_WORD_ALT;
      add_token(t);
      t = word(C_ADD);
      t.kind = K_WORD_ALT;
      add_token(t);
      t = word(C_CODE_MAX);
      t.ident = '1;
      add_token(t);
      t = variable_tok();
      t.ident = '1;
      add_token(t);
      add_token(word(C_STORE));
      t = literal_tok(64'h8000_0000_0000_0000);
      t.code  = '0;
      t.ident = '0;
      add_token(t);
      add_token(word(C_LT));
      end_list();
      add_token(literal_tok('1));
      end_list();
   endfunction

   // a fusable pattern with random content, or a single word or literal, occasionally broken by noise
   function automatic void add_pattern(int sel);
      tok_type seq [$];
      if (sel < 2) begin
         seq = {seq, word(C_RFROM)};
         seq = {seq, literal_tok(pick_literal())};
         seq = {seq, word(sel == 0 ? C_ADD : C_SUB)};
         seq = {seq, word(C_TOR)};
      end else if (sel < 8) begin
         seq = {seq, word(PAIR_HEAD[sel - 2])};
         seq = {seq, word(PAIR_TAIL[sel - 2])};
      end else if (sel < 10) begin
         seq = {seq, variable_tok()};
         seq = {seq, word(sel == 8 ? C_FETCH : C_STORE)};
      end else if (sel < 17) begin
         seq = {seq, literal_tok(pick_literal())};
         seq = {seq, word(LIT_OPS[sel - 10])};
      end else if (sel == 17) begin
         seq = {seq, word(5'($urandom_range(0, 31)))};
      end else begin
         seq = {seq, literal_tok(pick_literal())};
      end
      foreach (seq[i]) add_token($urandom_range(0, 9) == 0 ? noise_tok() : seq[i]);
   endfunction

   function automatic void build_random();
      int start_size;
      start_size = token_list.size();
      while (token_list.size() - start_size < RANDOM_TOKENS) begin
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_token(noise_tok());
            else add_pattern($urandom_range(0, 18));
         end
         end_list();
      end
   endfunction

   // receiver: free running, random stalls, and long holds
   initial begin
      int seg;
      int mode;
      int span;
      rsp_stall = 1'b0;
      seg = 0;
      wait (reset === 1'b0);
      forever begin
         mode = (seg == 2) ? 2 : $urandom_range(0, 7);
         span = (mode == 2) ? $urandom_range(40, 80) : $urandom_range(5, 40);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0, 1:    rsp_stall <= 1'b0;
               2:       rsp_stall <= 1'b1;
               6, 7:    rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= ($urandom_range(0, 99) < 30);
            endcase
         end
         seg++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int next;
      int burst;
      int gap;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_token_kind    = '0;
      req_word_code     = '0;
      req_word_ident    = '0;
      req_literal_value = '0;
      req_last_token    = 1'b0;
      list_count        = 0;
      build_directed();
      build_random();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      next = 0;
      while (next < token_list.size()) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && next < token_list.size()) begin
            @(negedge clock);
            req_valid         <= 1'b1;
            req_token_kind    <= token_list[next].tok.kind;
            req_word_code     <= token_list[next].tok.code;
            req_word_ident    <= token_list[next].tok.ident;
            req_literal_value <= token_list[next].tok.literal;
            req_last_token    <= token_list[next].last;
            @(posedge clock);
            while (req_stall) @(posedge clock);
            next++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expect_depth == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d tokens in %0d token lists: all fusion patterns, kinds and codes",
               token_list.size(), list_count);
      $display("Compared %0d results: %0d fused, %0d divide-by-zero errors",
               results_seen, fused_seen, div0_seen);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
